@@ hdl/cmpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpm_pkg: shared definitions of the caseless multi-pattern matcher
// Sizes, operation codes, the queue entry and stage records, and the
// ASCII case folding helpers.
// ----------------------------------------------------------------------------
package cmpm_pkg;

  localparam int NUM_PATTERNS    = 4;
  localparam int MAX_PATTERN_LEN = 64;

  localparam int OP_W    = 2;
  localparam int DATA_W  = 16;
  localparam int SLOT_W  = 2;
  localparam int LEN_W   = 7;
  localparam int POS_W   = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
  localparam int COUNT_W = 32;

  localparam logic [COUNT_W-1:0] SCAN_LIMIT_RESET = 32'd10485760;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN     = 2'd0,
    OP_WRITE    = 2'd1,
    OP_LENGTH   = 2'd2,
    OP_RESERVED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_NOP,
    K_SCAN,
    K_WRITE,
    K_LENGTH
  } kind_t;

  // One classified item as it waits in the queue.
  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  pos;
    logic [LEN_W-1:0]  len;
    logic              wide;
    logic              last;
    logic [7:0]        scan_byte;
    logic [7:0]        key_narrow;
    logic [15:0]       key_wide;
  } entry_t;

  // Compare results handed from the compare stage to the tracking stage.
  typedef struct packed {
    kind_t                                          kind;
    logic [SLOT_W-1:0]                              slot;
    logic                                           last;
    logic [NUM_PATTERNS-1:0]                        adv;
    logic [NUM_PATTERNS-1:0][MAX_PATTERN_LEN-1:0]   mask;
    logic [NUM_PATTERNS-1:0][POS_W-1:0]             hit_pos;
  } stage_t;

  function automatic logic [7:0] fold8(logic [7:0] v);
    logic [7:0] r;
    r = v;
    if (v >= CHAR_UPPER_A && v <= CHAR_UPPER_Z) begin
      r = v + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [15:0] fold16(logic [15:0] v);
    logic [15:0] r;
    r = v;
    if (v >= {8'h00, CHAR_UPPER_A} && v <= {8'h00, CHAR_UPPER_Z}) begin
      r = v + {8'h00, CASE_OFFSET};
    end
    return r;
  endfunction

endpackage

@@ hdl/cmpm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpm_front: input acceptance and classification
// Decodes each item, drops out-of-range writes, saturates lengths and
// precomputes folded character keys before the item enters the queue.
// ----------------------------------------------------------------------------
module cmpm_front (
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cmpm_pkg::OP_W-1:0]      operation,
  input  logic [cmpm_pkg::DATA_W-1:0]    data_value,
  input  logic [cmpm_pkg::SLOT_W-1:0]    pattern_slot,
  input  logic [cmpm_pkg::LEN_W-1:0]     char_position,
  input  logic                           wide_chars,
  input  logic                           region_last,
  input  logic                           queue_full,
  output logic                           push,
  output cmpm_pkg::entry_t               push_entry
);

  logic slot_ok;
  logic pos_ok;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  assign slot_ok = int'(pattern_slot) < cmpm_pkg::NUM_PATTERNS;
  assign pos_ok  = int'(char_position) < cmpm_pkg::MAX_PATTERN_LEN;

  always_comb begin
    push_entry            = '0;
    push_entry.slot       = pattern_slot;
    push_entry.pos        = cmpm_pkg::POS_W'(char_position);
    push_entry.wide       = wide_chars;
    push_entry.last       = region_last;
    push_entry.scan_byte  = data_value[7:0];
    push_entry.key_narrow = cmpm_pkg::fold8(data_value[7:0]);
    push_entry.key_wide   = cmpm_pkg::fold16(data_value);
    if (int'(char_position) > cmpm_pkg::MAX_PATTERN_LEN) begin
      push_entry.len = cmpm_pkg::LEN_W'(cmpm_pkg::MAX_PATTERN_LEN);
    end else begin
      push_entry.len = char_position;
    end
    case (cmpm_pkg::op_t'(operation))
      cmpm_pkg::OP_SCAN: begin
        push_entry.kind = cmpm_pkg::K_SCAN;
      end
      cmpm_pkg::OP_WRITE: begin
        push_entry.kind = (slot_ok && pos_ok) ? cmpm_pkg::K_WRITE : cmpm_pkg::K_NOP;
      end
      cmpm_pkg::OP_LENGTH: begin
        push_entry.kind = slot_ok ? cmpm_pkg::K_LENGTH : cmpm_pkg::K_NOP;
      end
      default: begin
        push_entry.kind = cmpm_pkg::K_NOP;
      end
    endcase
  end

endmodule

@@ hdl/cmpm_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpm_queue: short FIFO between the front and the back
// Holds classified items so that each side can stall on its own.
// ----------------------------------------------------------------------------
module cmpm_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  cmpm_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output cmpm_pkg::entry_t head
);

  cmpm_pkg::entry_t                 slots [cmpm_pkg::QUEUE_DEPTH];
  logic [cmpm_pkg::QPTR_W-1:0]      wr_ptr;
  logic [cmpm_pkg::QPTR_W-1:0]      rd_ptr;
  logic [cmpm_pkg::QCNT_W-1:0]      count;

  function automatic logic [cmpm_pkg::QPTR_W-1:0] ptr_inc(logic [cmpm_pkg::QPTR_W-1:0] p);
    logic [cmpm_pkg::QPTR_W-1:0] r;
    if (int'(p) == cmpm_pkg::QUEUE_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  assign full       = count == cmpm_pkg::QCNT_W'(cmpm_pkg::QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hdl/cmpm_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpm_compare: pattern store and parallel character compare
// Applies pattern writes and lengths, tracks the region offset and the held
// low byte, and compares every stored position against the current character.
// ----------------------------------------------------------------------------
module cmpm_compare (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [cmpm_pkg::COUNT_W-1:0] scan_limit,
  input  logic                         head_valid,
  input  cmpm_pkg::entry_t             head,
  output logic                         pop,
  output logic                         stage_valid,
  output cmpm_pkg::stage_t             stage,
  input  logic                         stage_ready
);

  // Folded characters; the entries hold nothing meaningful until written.
  logic [7:0]  key_narrow [cmpm_pkg::NUM_PATTERNS][cmpm_pkg::MAX_PATTERN_LEN];
  logic [15:0] key_wide   [cmpm_pkg::NUM_PATTERNS][cmpm_pkg::MAX_PATTERN_LEN];

  logic [cmpm_pkg::LEN_W-1:0]        len     [cmpm_pkg::NUM_PATTERNS];
  logic [cmpm_pkg::NUM_PATTERNS-1:0] is_wide;
  logic [cmpm_pkg::COUNT_W-1:0]      byte_count;
  logic [7:0]                        held_byte;

  logic              below_limit;
  logic              odd;
  logic [15:0]       pair_key;
  cmpm_pkg::stage_t  stage_next;

  assign pop         = head_valid && (!stage_valid || stage_ready);
  assign below_limit = byte_count < scan_limit;
  assign odd         = byte_count[0];
  assign pair_key    = cmpm_pkg::fold16({head.scan_byte, held_byte});

  always_comb begin
    stage_next      = '0;
    stage_next.kind = head.kind;
    stage_next.slot = head.slot;
    stage_next.last = head.last;
    for (int s = 0; s < cmpm_pkg::NUM_PATTERNS; s++) begin
      stage_next.adv[s] = (head.kind == cmpm_pkg::K_SCAN) && below_limit &&
                          (len[s] != '0) && (!is_wide[s] || odd);
      stage_next.hit_pos[s] = cmpm_pkg::POS_W'(len[s] - 1'b1);
      for (int j = 0; j < cmpm_pkg::MAX_PATTERN_LEN; j++) begin
        stage_next.mask[s][j] = (j < int'(len[s])) &&
                                (is_wide[s] ? (key_wide[s][j] == pair_key)
                                            : (key_narrow[s][j] == head.key_narrow));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < cmpm_pkg::NUM_PATTERNS; s++) begin
        len[s] <= '0;
      end
      is_wide     <= '0;
      byte_count  <= '0;
      held_byte   <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (pop) begin
        stage_valid <= 1'b1;
      end else if (stage_ready) begin
        stage_valid <= 1'b0;
      end
      if (pop) begin
        case (head.kind)
          cmpm_pkg::K_LENGTH: begin
            len[head.slot]     <= head.len;
            is_wide[head.slot] <= head.wide;
          end
          cmpm_pkg::K_SCAN: begin
            if (head.last) begin
              byte_count <= '0;
              held_byte  <= '0;
            end else begin
              if (byte_count != '1) begin
                byte_count <= byte_count + 1'b1;
              end
              if (below_limit && !odd) begin
                held_byte <= head.scan_byte;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      stage <= stage_next;
      if (head.kind == cmpm_pkg::K_WRITE) begin
        key_narrow[head.slot][head.pos] <= head.key_narrow;
        key_wide[head.slot][head.pos]   <= head.key_wide;
      end
    end
  end

endmodule

@@ hdl/cmpm_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmpm_track: shift-and state, found flag and result register
// Advances the partial matches of each pattern and registers one result for
// every item.
// ----------------------------------------------------------------------------
module cmpm_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             stage_valid,
  input  cmpm_pkg::stage_t stage,
  output logic             stage_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             pattern_found,
  output logic             region_done
);

  logic [cmpm_pkg::NUM_PATTERNS-1:0][cmpm_pkg::MAX_PATTERN_LEN-1:0] partial;
  logic [cmpm_pkg::NUM_PATTERNS-1:0][cmpm_pkg::MAX_PATTERN_LEN-1:0] partial_next;
  logic [cmpm_pkg::NUM_PATTERNS-1:0]                                hit;
  logic                                                             found_flag;
  logic                                                             found_now;
  logic                                                             advance;
  logic                                                             is_scan;

  assign stage_ready = !out_valid || out_ready;
  assign advance     = stage_valid && stage_ready;
  assign is_scan     = stage.kind == cmpm_pkg::K_SCAN;

  always_comb begin
    for (int s = 0; s < cmpm_pkg::NUM_PATTERNS; s++) begin
      partial_next[s] = ((partial[s] << 1) | cmpm_pkg::MAX_PATTERN_LEN'(1)) & stage.mask[s];
      hit[s]          = stage.adv[s] && partial_next[s][stage.hit_pos[s]];
    end
    found_now = found_flag || (|hit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial    <= '0;
      found_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        case (stage.kind)
          cmpm_pkg::K_SCAN: begin
            if (stage.last) begin
              partial    <= '0;
              found_flag <= 1'b0;
            end else begin
              for (int s = 0; s < cmpm_pkg::NUM_PATTERNS; s++) begin
                if (stage.adv[s]) begin
                  partial[s] <= partial_next[s];
                end
              end
              found_flag <= found_now;
            end
          end
          cmpm_pkg::K_LENGTH: begin
            partial[stage.slot] <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pattern_found <= is_scan && found_now;
      region_done   <= is_scan && stage.last;
    end
  end

endmodule

@@ hdl/caseless_multi_pattern_matcher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caseless_multi_pattern_matcher: case-insensitive multi-pattern search
// Streams the bytes of a memory region and reports whether any of the loaded
// byte or 16-bit patterns occurs in it, with ASCII letters folded.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                   Payload
//   --------  --------------------------  -----------------------------------
//   input     in_valid / in_ready         operation, data_value, pattern_slot,
//                                         char_position, wide_chars,
//                                         region_last
//   output    out_valid / out_ready       pattern_found, region_done
//   config    cfg_write_enable            cfg_write_data (scan limit in bytes)
//
// One item is taken per cycle while in_ready is high, and every item gives
// exactly one result. A result passes through the queue, the compare stage
// and the result register, in that order.
// Reset is synchronous and active high. It clears the pattern lengths, the
// match state, the byte counter and the scan limit (to 10 MiB); the pattern
// characters are not cleared and only count once written.
// A stall on the output holds the result register and backs up through the
// compare stage into the two-entry queue; in_ready drops only when the queue
// is full.
//
// The front classifies each item and folds pattern characters to lower case
// before queueing. The compare stage holds the pattern store and compares
// the current character (a byte, or a completed even-aligned byte pair for
// wide patterns) against every pattern position at once. The tracking stage
// applies the shift-and update to the partial-match vectors, keeps the sticky
// found flag, and clears both after the last byte of a region.
// ----------------------------------------------------------------------------
module caseless_multi_pattern_matcher (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cmpm_pkg::OP_W-1:0]    operation,
  input  logic [cmpm_pkg::DATA_W-1:0]  data_value,
  input  logic [cmpm_pkg::SLOT_W-1:0]  pattern_slot,
  input  logic [cmpm_pkg::LEN_W-1:0]   char_position,
  input  logic                         wide_chars,
  input  logic                         region_last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         pattern_found,
  output logic                         region_done,
  input  logic                         cfg_write_enable,
  input  logic [cmpm_pkg::COUNT_W-1:0] cfg_write_data
);

  // The user must change the scan limit only while the block is idle; the
  // block itself does not enforce it, and the compare stage reads it directly.
  logic [cmpm_pkg::COUNT_W-1:0] scan_limit;

  logic             push;
  cmpm_pkg::entry_t push_entry;
  logic             queue_full;
  logic             pop;
  logic             head_valid;
  cmpm_pkg::entry_t head;
  logic             stg_valid;
  logic             stg_ready;
  cmpm_pkg::stage_t stg;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= cmpm_pkg::SCAN_LIMIT_RESET;
    end else if (cfg_write_enable) begin
      scan_limit <= cfg_write_data;
    end
  end

  cmpm_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .data_value    (data_value),
    .pattern_slot  (pattern_slot),
    .char_position (char_position),
    .wide_chars    (wide_chars),
    .region_last   (region_last),
    .queue_full    (queue_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  cmpm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  cmpm_compare u_compare (
    .clk         (clk),
    .rst         (rst),
    .scan_limit  (scan_limit),
    .head_valid  (head_valid),
    .head        (head),
    .pop         (pop),
    .stage_valid (stg_valid),
    .stage       (stg),
    .stage_ready (stg_ready)
  );

  cmpm_track u_track (
    .clk           (clk),
    .rst           (rst),
    .stage_valid   (stg_valid),
    .stage         (stg),
    .stage_ready   (stg_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .pattern_found (pattern_found),
    .region_done   (region_done)
  );

  // Only scan items may advance any pattern.
  a_adv_only_on_scan : assert property (@(posedge clk) disable iff (rst)
    (stg_valid && stg.kind != cmpm_pkg::K_SCAN) |-> (stg.adv == '0))
    else $error("pattern advance on a non-scan item");

  // A compare result that is held back keeps its contents.
  a_stage_holds : assert property (@(posedge clk) disable iff (rst)
    (stg_valid && !stg_ready) |=> (stg_valid && $stable(stg)))
    else $error("compare stage changed while stalled");

  // A non-scan item always answers with both flags low.
  a_non_scan_result : assert property (@(posedge clk) disable iff (rst)
    (stg_valid && stg_ready && stg.kind != cmpm_pkg::K_SCAN)
      |=> (out_valid && !pattern_found && !region_done))
    else $error("non-scan item produced a nonzero result");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the caseless multi-pattern matcher
// Loads byte and 16-bit patterns, streams regions that hold them (with random
// letter case, filler, broken copies and misaligned wide pairs) and compares
// every result against a cycle-free prediction of the matcher, under random
// stalls on both channels and several scan limits.
// ----------------------------------------------------------------------------
module testbench;
  import cmpm_pkg::*;

  // A cycle with no transfer on either channel this many times in a row
  // means the block has hung.
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic found;
    logic done;
  } match_verdict_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [OP_W-1:0]      operation;
  logic [DATA_W-1:0]    data_value;
  logic [SLOT_W-1:0]    pattern_slot;
  logic [LEN_W-1:0]     char_position;
  logic                 wide_chars;
  logic                 region_last;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 pattern_found;
  logic                 region_done;
  logic                 cfg_write_enable;
  logic [COUNT_W-1:0]   cfg_write_data;

  caseless_multi_pattern_matcher u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .data_value       (data_value),
    .pattern_slot     (pattern_slot),
    .char_position    (char_position),
    .wide_chars       (wide_chars),
    .region_last      (region_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .pattern_found    (pattern_found),
    .region_done      (region_done),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predicted matcher state. It is advanced once per input transfer, in the
  // same clocked process that checks results, so that the prediction and the
  // comparison never race each other.
  // --------------------------------------------------------------------------
  logic [15:0]        pm_chars   [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [LEN_W-1:0]   pm_len     [NUM_PATTERNS];
  logic               pm_wide    [NUM_PATTERNS];
  logic [63:0]        pm_partial [NUM_PATTERNS];
  logic [COUNT_W-1:0] pm_count;
  logic [7:0]         pm_held;
  logic               pm_found;
  logic [COUNT_W-1:0] pm_limit;

  match_verdict_t verdicts_due[$];
  int             mismatch_count;
  int             items_sent;
  int             send_idle_pct;
  int             recv_idle_pct;
  int             quiet_cycles;

  // What the stimulus side knows it has loaded. It keeps every scan clear of
  // pattern characters that were never written, and lets regions embed the
  // patterns that are currently active.
  bit          char_written  [NUM_PATTERNS][MAX_PATTERN_LEN];
  logic [15:0] loaded_chars  [NUM_PATTERNS][MAX_PATTERN_LEN];
  int          loaded_len    [NUM_PATTERNS];
  bit          loaded_wide   [NUM_PATTERNS];
  int          region_offset;

  // Only the ASCII capitals are folded; every other code, including the
  // upper byte of a 16-bit character, compares as it is.
  function automatic logic [15:0] to_lower16(logic [15:0] v);
    if (v >= 16'h0041 && v <= 16'h005A) begin
      return v + 16'h0020;
    end
    return v;
  endfunction

  // Shift-and step of one pattern on one folded character. Returns whether
  // the last position of the pattern is now matched.
  function automatic logic advance_slot(int s, logic [15:0] c);
    logic [63:0] hits;
    logic [15:0] pc;
    int          len;
    hits = '0;
    len  = int'(pm_len[s]);
    for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
      if (j < len) begin
        pc = pm_wide[s] ? pm_chars[s][j] : {8'h00, pm_chars[s][j][7:0]};
        if (to_lower16(pc) == c) begin
          hits[j] = 1'b1;
        end
      end
    end
    pm_partial[s] = ((pm_partial[s] << 1) | 64'd1) & hits;
    return pm_partial[s][len-1];
  endfunction

  // Applies one input item to the predicted state and returns the result
  // that the block must give for it.
  function automatic match_verdict_t predict_verdict(op_t op, logic [15:0] data,
                                                     logic [SLOT_W-1:0] slot,
                                                     logic [LEN_W-1:0] pos,
                                                     logic wide, logic last);
    match_verdict_t v;
    logic [7:0]     b;
    logic           odd;
    v = '0;
    b = data[7:0];
    case (op)
      OP_WRITE: begin
        if (pos < LEN_W'(MAX_PATTERN_LEN)) begin
          pm_chars[slot][pos[POS_W-1:0]] = data;
        end
      end
      OP_LENGTH: begin
        // Oversized lengths saturate, and a new length drops the slot's
        // partial matches.
        pm_len[slot]     = (pos > LEN_W'(MAX_PATTERN_LEN)) ? LEN_W'(MAX_PATTERN_LEN) : pos;
        pm_wide[slot]    = wide;
        pm_partial[slot] = '0;
      end
      OP_SCAN: begin
        // Bytes at or past the limit are counted but leave the matches alone.
        if (pm_count < pm_limit) begin
          odd = pm_count[0];
          for (int s = 0; s < NUM_PATTERNS; s++) begin
            if (pm_len[s] != '0) begin
              if (pm_wide[s]) begin
                // A wide pattern only moves once the even-aligned pair is whole.
                if (odd && advance_slot(s, to_lower16({b, pm_held}))) begin
                  pm_found = 1'b1;
                end
              end else if (advance_slot(s, to_lower16({8'h00, b}))) begin
                pm_found = 1'b1;
              end
            end
          end
          if (!odd) begin
            pm_held = b;
          end
        end
        if (pm_count != '1) begin
          pm_count = pm_count + 1'b1;
        end
        v.found = pm_found;
        if (last) begin
          // The result carries the region's flag; the state clears after it.
          v.done = 1'b1;
          for (int s = 0; s < NUM_PATTERNS; s++) begin
            pm_partial[s] = '0;
          end
          pm_found = 1'b0;
          pm_count = '0;
          pm_held  = '0;
        end
      end
      default: begin
        // The reserved operation answers with an all-zero result.
      end
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
  endtask

  // --------------------------------------------------------------------------
  // Scoreboard: predicts on every input transfer and checks every output
  // transfer against the oldest outstanding verdict.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    match_verdict_t due;
    if (rst) begin
      for (int s = 0; s < NUM_PATTERNS; s++) begin
        pm_len[s]     = '0;
        pm_wide[s]    = 1'b0;
        pm_partial[s] = '0;
      end
      pm_count = '0;
      pm_held  = '0;
      pm_found = 1'b0;
      pm_limit = SCAN_LIMIT_RESET;
      verdicts_due.delete();
    end else begin
      if (cfg_write_enable) begin
        pm_limit = cfg_write_data;
      end
      if (in_valid && in_ready) begin
        verdicts_due.push_back(predict_verdict(op_t'(operation), data_value, pattern_slot,
                                               char_position, wide_chars, region_last));
      end
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result (found %0b, done %0b) with no item outstanding",
                                    pattern_found, region_done));
        end else begin
          due = verdicts_due.pop_front();
          if (pattern_found !== due.found) begin
            report_mismatch($sformatf("pattern_found is %0b, predicted %0b",
                                      pattern_found, due.found));
          end
          if (region_done !== due.done) begin
            report_mismatch($sformatf("region_done is %0b, predicted %0b",
                                      region_done, due.done));
          end
        end
      end
    end
  end

  // The receiver stalls at random with the probability of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Hang detection: too long without any transfer ends the run as a failure.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Sends one item: random idle cycles first, then valid held with a steady
  // payload until the transfer happens. Returns at the edge of the transfer.
  task automatic send_item(input op_t op, input logic [15:0] data,
                           input logic [SLOT_W-1:0] slot, input logic [LEN_W-1:0] pos,
                           input logic wide, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    data_value    <= data;
    pattern_slot  <= slot;
    char_position <= pos;
    wide_chars    <= wide;
    region_last   <= last;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    items_sent++;
    case (op)
      OP_WRITE: begin
        if (pos < LEN_W'(MAX_PATTERN_LEN)) begin
          char_written[slot][pos[POS_W-1:0]] = 1'b1;
          loaded_chars[slot][pos[POS_W-1:0]] = data;
        end
      end
      OP_LENGTH: begin
        loaded_len[slot]  = (int'(pos) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(pos);
        loaded_wide[slot] = wide;
      end
      OP_SCAN: begin
        region_offset = last ? 0 : region_offset + 1;
      end
      default: begin
      end
    endcase
  endtask

  // Stops offering items and waits until every result has come back. The
  // first edge lets the scoreboard record the item that was transferred at the
  // calling edge.
  task automatic hold_and_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdicts_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (5) @(posedge clk);
  endtask

  // Only called with the block drained.
  task automatic set_scan_limit(input logic [COUNT_W-1:0] limit);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= limit;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] flip_case(logic [7:0] v);
    logic [7:0] low;
    low = v | 8'h20;
    if (low >= 8'h61 && low <= 8'h7A && $urandom_range(1) == 1) begin
      return v ^ 8'h20;
    end
    return v;
  endfunction

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(1) == 1) begin
      return flip_case(8'(8'h61 + $urandom_range(25)));
    end
    return 8'($urandom_range(255));
  endfunction

  // Pattern characters are mostly letters of either case; both kinds are
  // sometimes arbitrary 16-bit codes, and narrow ones carry a random upper byte.
  function automatic logic [15:0] pick_char(logic wide);
    logic [7:0] letter;
    letter = flip_case(8'(8'h61 + $urandom_range(25)));
    if (wide) begin
      return ($urandom_range(99) < 70) ? {8'h00, letter} : 16'($urandom);
    end
    if ($urandom_range(99) < 20) begin
      return 16'($urandom);
    end
    return {8'($urandom_range(255)), letter};
  endfunction

  // A scan item; the fields that a scan does not use carry random values.
  task automatic scan_byte(input logic [7:0] b, input logic last);
    send_item(OP_SCAN, {8'($urandom_range(255)), b}, SLOT_W'($urandom_range(3)),
              LEN_W'($urandom_range(127)), 1'($urandom_range(1)), last);
  endtask

  // Sets a length; any character in the used prefix that was never written
  // is written first, so no scan can touch an undefined character.
  task automatic load_pattern(input int s, input logic [LEN_W-1:0] len, input logic wide);
    int used;
    used = (int'(len) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len);
    for (int j = 0; j < used; j++) begin
      if (!char_written[s][j]) begin
        send_item(OP_WRITE, pick_char(wide), SLOT_W'(s), LEN_W'(j),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
    send_item(OP_LENGTH, 16'($urandom), SLOT_W'(s), len, wide, 1'($urandom_range(1)));
  endtask

  // Fresh random content for a whole pattern, then its length.
  task automatic new_pattern(input int s, input logic [LEN_W-1:0] len, input logic wide);
    int used;
    used = (int'(len) > MAX_PATTERN_LEN) ? MAX_PATTERN_LEN : int'(len);
    for (int j = 0; j < used; j++) begin
      send_item(OP_WRITE, pick_char(wide), SLOT_W'(s), LEN_W'(j),
                1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    load_pattern(s, len, wide);
  endtask

  // Streams a loaded pattern with random letter case. Wide patterns are put
  // on an even offset as little-endian pairs. A broken copy has its last
  // character altered so that it must not complete.
  task automatic embed_pattern(input int s, input bit broken);
    logic [15:0] c;
    int          n;
    n = loaded_len[s];
    if (loaded_wide[s] && (region_offset % 2 == 1)) begin
      scan_byte(filler_byte(), 1'b0);
    end
    for (int j = 0; j < n; j++) begin
      c = loaded_chars[s][j];
      if (broken && j == n - 1) begin
        c = c ^ 16'h0101;
      end
      if (loaded_wide[s]) begin
        if (c[15:8] == 8'h00) begin
          c[7:0] = flip_case(c[7:0]);
        end
        scan_byte(c[7:0], 1'b0);
        scan_byte(c[15:8], 1'b0);
      end else begin
        scan_byte(flip_case(c[7:0]), 1'b0);
      end
    end
  endtask

  // One region: a few pieces of filler, each followed mostly by an active
  // pattern, closed by a last byte.
  task automatic send_region();
    int active[$];
    int pieces;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      if (loaded_len[s] != 0) begin
        active.push_back(s);
      end
    end
    pieces = $urandom_range(1, 3);
    for (int p = 0; p < pieces; p++) begin
      repeat ($urandom_range(4)) scan_byte(filler_byte(), 1'b0);
      if (active.size() != 0 && $urandom_range(99) < 85) begin
        embed_pattern(active[$urandom_range(active.size() - 1)], $urandom_range(99) < 15);
      end
    end
    scan_byte(filler_byte(), 1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Byte pattern "AbC" whose last two stored characters carry junk upper bytes. It
  // matches "aBc" in data, the flag stays up to the region's last byte, and a
  // length item between the pieces of a match breaks it.
  task automatic test_byte_pattern();
    send_item(OP_WRITE, 16'h0041, 2'd0, 7'd0, 1'b0, 1'b0);
    send_item(OP_WRITE, 16'h7F62, 2'd0, 7'd1, 1'b1, 1'b1);
    send_item(OP_WRITE, 16'hFF43, 2'd0, 7'd2, 1'b0, 1'b0);
    load_pattern(0, 7'd3, 1'b0);
    scan_byte(8'h78, 1'b0);
    scan_byte(8'h61, 1'b0);
    scan_byte(8'h42, 1'b0);
    scan_byte(8'h63, 1'b0);
    send_item(OP_SCAN, 16'hFFFF, 2'd3, 7'd127, 1'b1, 1'b1);
    scan_byte(8'h41, 1'b0);
    scan_byte(8'h62, 1'b0);
    load_pattern(0, 7'd3, 1'b0);
    scan_byte(8'h43, 1'b1);
  endtask

  // Wide pattern {'H', 0x4E2D}: it matches on an even offset, not on an odd
  // one, and a trailing unpaired byte never completes it.
  task automatic test_wide_pattern();
    send_item(OP_WRITE, 16'h0048, 2'd1, 7'd0, 1'b1, 1'b0);
    send_item(OP_WRITE, 16'h4E2D, 2'd1, 7'd1, 1'b1, 1'b0);
    load_pattern(1, 7'd2, 1'b1);
    scan_byte(8'h68, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h2D, 1'b0);
    scan_byte(8'h4E, 1'b1);
    scan_byte(8'h11, 1'b0);
    scan_byte(8'h68, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h2D, 1'b0);
    scan_byte(8'h4E, 1'b1);
    scan_byte(8'h48, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h2D, 1'b1);
  endtask

  // Reserved operation, writes past the last position, a zero length, and a
  // length past the maximum that saturates to a full-size pattern.
  task automatic test_special_items();
    send_item(OP_RESERVED, 16'hFFFF, 2'd3, 7'd127, 1'b1, 1'b1);
    send_item(OP_RESERVED, 16'h0000, 2'd0, 7'd0, 1'b0, 1'b0);
    send_item(OP_WRITE, 16'hFFFF, 2'd2, 7'd64, 1'b1, 1'b1);
    send_item(OP_WRITE, 16'h0061, 2'd2, 7'd127, 1'b0, 1'b0);
    load_pattern(2, 7'd0, 1'b0);
    new_pattern(3, 7'd127, 1'b0);
    embed_pattern(3, 1'b0);
    scan_byte(8'h00, 1'b1);
    load_pattern(3, 7'd4, 1'b1);
  endtask

  // Scan limits of zero, a few bytes and the maximum, each written with the
  // block drained. With a limit of three, "abc" at the start of a region
  // matches but one byte later it does not.
  task automatic test_scan_limit();
    hold_and_drain();
    set_scan_limit('0);
    scan_byte(8'h61, 1'b0);
    scan_byte(8'h62, 1'b0);
    scan_byte(8'h63, 1'b1);
    hold_and_drain();
    set_scan_limit(32'd3);
    scan_byte(8'h61, 1'b0);
    scan_byte(8'h62, 1'b0);
    scan_byte(8'h63, 1'b0);
    scan_byte(8'h78, 1'b1);
    scan_byte(8'h78, 1'b0);
    scan_byte(8'h61, 1'b0);
    scan_byte(8'h62, 1'b0);
    scan_byte(8'h63, 1'b1);
    hold_and_drain();
    set_scan_limit('1);
    scan_byte(8'h41, 1'b0);
    scan_byte(8'h62, 1'b0);
    scan_byte(8'h43, 1'b1);
  endtask

  // Random traffic: mostly whole regions built around the loaded patterns,
  // now and then a fresh pattern, and some stray items of every kind.
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [COUNT_W-1:0] limit, input int count);
    int          goal;
    int          pick;
    int          len;
    logic [SLOT_W-1:0] slot;
    hold_and_drain();
    set_scan_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      slot = SLOT_W'($urandom_range(3));
      if (pick < 15) begin
        len = $urandom_range(99);
        if (len < 5) begin
          len = 0;
        end else if (len < 80) begin
          len = $urandom_range(1, 6);
        end else if (len < 96) begin
          len = $urandom_range(7, 16);
        end else begin
          len = $urandom_range(65, 127);
        end
        new_pattern(int'(slot), LEN_W'(len), 1'($urandom_range(1)));
      end else if (pick < 80) begin
        send_region();
      end else begin
        case (op_t'(2'($urandom_range(3))))
          OP_SCAN:   scan_byte(8'($urandom_range(255)), $urandom_range(99) < 20);
          OP_WRITE:  send_item(OP_WRITE, 16'($urandom), slot, LEN_W'($urandom_range(127)),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
          OP_LENGTH: load_pattern(int'(slot), LEN_W'($urandom_range(127)),
                                  1'($urandom_range(1)));
          default:   send_item(OP_RESERVED, 16'($urandom), slot, LEN_W'($urandom_range(127)),
                               1'($urandom_range(1)), 1'($urandom_range(1)));
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    in_valid         <= 1'b0;
    operation        <= OP_SCAN;
    data_value       <= '0;
    pattern_slot     <= '0;
    char_position    <= '0;
    wide_chars       <= 1'b0;
    region_last      <= 1'b0;
    cfg_write_enable <= 1'b0;
    cfg_write_data   <= '0;
    mismatch_count   = 0;
    items_sent       = 0;
    quiet_cycles     = 0;
    region_offset    = 0;
    send_idle_pct    = 24;
    recv_idle_pct    = 67;
    for (int s = 0; s < NUM_PATTERNS; s++) begin
      loaded_len[s]  = 0;
      loaded_wide[s] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The first directed tests run with the limit left at its reset value.
    test_byte_pattern();
    test_wide_pattern();
    test_special_items();
    test_scan_limit();

    test_random_traffic(24, 67, '1, 120);
    test_random_traffic(67, 24, COUNT_W'($urandom_range(2, 40)), 120);
    test_random_traffic(0, 0, SCAN_LIMIT_RESET, 120);

    hold_and_drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/cmpm_pkg.sv
hdl/cmpm_front.sv
hdl/cmpm_queue.sv
hdl/cmpm_compare.sv
hdl/cmpm_track.sv
hdl/caseless_multi_pattern_matcher.sv
tb/sv/testbench.sv
